/* src/sem_pkg.sv */
// shared types and constants for the sobel edge magnitude block
package sem_pkg;
  localparam int MaxWidth = 2048;
  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = 12;
  localparam int CfgW = 12;
  localparam int PixW = 24;
  localparam int QDepth = 4;
  localparam int QAw = $clog2(QDepth);
  localparam logic [0:0] CfgWidth = 1'b0;
  localparam logic [0:0] CfgHeight = 1'b1;

  // one 3x3 window with its result tag, front to back
  typedef struct packed {
    logic [8:0][PixW-1:0] win;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic done;
  } win_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic done;
  } res_t;
endpackage

/* src/sem_front.sv */
// front end: counters, line stores, window and interior classification
module sem_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_addr_i,
  input  logic [sem_pkg::CfgW-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic frame_start_i,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  output logic win_valid_o,
  output sem_pkg::win_t win_o,
  input  logic win_stall_i
);
  localparam int ColW = sem_pkg::ColW;
  localparam int RowW = sem_pkg::RowW;
  localparam int PixW = sem_pkg::PixW;

  logic [sem_pkg::CfgW-1:0] width_q, height_q;
  logic [ColW:0] w_eff;
  logic [RowW-1:0] h_eff;
  logic [ColW:0] col_q, col_d, c;
  logic [RowW-1:0] row_q, row_d, r;
  logic [PixW-1:0] upper_mem [sem_pkg::MaxWidth];
  logic [PixW-1:0] middle_mem [sem_pkg::MaxWidth];
  logic [PixW-1:0] win_q [6];
  logic [PixW-1:0] px, top, mid;
  logic [PixW-1:0] top_q, mid_q;
  logic rd_q;
  logic acc;

  // an item is first held while the line stores are read into registers, and is then
  // accepted once the queue has room
  assign in_stall_o = !rd_q || win_stall_i;
  assign acc = in_valid_i && rd_q && !win_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 12'd640;
      height_q <= 12'd480;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sem_pkg::CfgWidth: width_q <= cfg_data_i;
        sem_pkg::CfgHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < 12'd3) w_eff = (ColW+1)'(3);
    else if ({1'b0, width_q} > 13'(sem_pkg::MaxWidth)) w_eff = (ColW+1)'(sem_pkg::MaxWidth);
    else w_eff = (ColW+1)'(width_q);
    h_eff = (height_q < 12'd3) ? 12'd3 : height_q;
  end

  always_comb begin
    c = frame_start_i ? '0 : col_q;
    r = frame_start_i ? '0 : row_q;
    if (c >= w_eff) c = '0;
    if (r >= h_eff) r = '0;
    col_d = c + 1'b1;
    row_d = r;
    if (col_d >= w_eff) begin
      col_d = '0;
      row_d = r + 1'b1;
      if (row_d >= h_eff) row_d = '0;
    end
  end

  assign px = {red_in_i, green_in_i, blue_in_i};
  assign top = top_q;
  assign mid = mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_q <= 1'b0;
    else if (acc) rd_q <= 1'b0;
    else if (in_valid_i) rd_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      upper_mem[c[ColW-1:0]] <= mid;
      middle_mem[c[ColW-1:0]] <= px;
    end
    if (in_valid_i && !rd_q) begin
      top_q <= upper_mem[c[ColW-1:0]];
      mid_q <= middle_mem[c[ColW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= px;
    end
  end

  // window order: a00 a10 a20 a01 a11 a21 a02 a12 a22
  assign win_valid_o = acc && r >= 12'd2 && c >= (ColW+1)'(2);
  always_comb begin
    win_o.win[0] = win_q[0];
    win_o.win[1] = win_q[1];
    win_o.win[2] = win_q[2];
    win_o.win[3] = win_q[3];
    win_o.win[4] = win_q[4];
    win_o.win[5] = win_q[5];
    win_o.win[6] = top;
    win_o.win[7] = mid;
    win_o.win[8] = px;
    win_o.row = r - 1'b1;
    win_o.col = ColW'(c - 1'b1);
    win_o.done = (r == h_eff - 1'b1) && (c == w_eff - 1'b1);
  end
endmodule

/* src/sem_queue.sv */
// short fifo between front and back
module sem_queue (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  sem_pkg::win_t data_i,
  output logic full_o,
  output logic valid_o,
  output sem_pkg::win_t data_o,
  input  logic pop_i
);
  localparam int Aw = sem_pkg::QAw;
  sem_pkg::win_t mem_q [sem_pkg::QDepth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0] cnt_q;

  assign full_o = cnt_q == (Aw+1)'(sem_pkg::QDepth);
  assign valid_o = cnt_q != '0;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) if (push_i) mem_q[wp_q] <= data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop_i);
    end
  end
endmodule

/* src/sem_back.sv */
// back end: sobel sums, clamp, squares, pipelined integer square root
module sem_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic win_valid_i,
  input  sem_pkg::win_t win_i,
  output logic win_pop_o,
  output logic out_valid_o,
  output sem_pkg::res_t res_o,
  input  logic out_stall_i
);
  // stages: 0 sums/clamp, 1 squares, 2..9 root bits, the last stage drives the outputs
  localparam int NS = 10;
  logic [NS-1:0] v_q;
  logic adv;
  logic [2:0][7:0] ux_q, uy_q;
  logic [2:0][16:0] n_q [NS];
  logic [2:0][7:0] rt_q [NS];
  logic [sem_pkg::RowW-1:0] row_q [NS];
  logic [sem_pkg::ColW-1:0] col_q [NS];
  logic done_q [NS];
  logic [2:0][7:0] ux, uy;

  // whole pipe moves together; holds while output is stalled and full
  assign adv = !(out_valid_o && out_stall_i);
  assign win_pop_o = win_valid_i && adv;

  function automatic logic [7:0] clamp_f(input logic signed [11:0] v);
    if (v < 0) return 8'd0;
    if (v > 12'sd255) return 8'd255;
    return v[7:0];
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [11:0] a00, a10, a20, a01, a21, a02, a12, a22, hy, hx;
      a00 = {4'd0, win_i.win[0][k*8 +: 8]};
      a10 = {4'd0, win_i.win[1][k*8 +: 8]};
      a20 = {4'd0, win_i.win[2][k*8 +: 8]};
      a01 = {4'd0, win_i.win[3][k*8 +: 8]};
      a21 = {4'd0, win_i.win[5][k*8 +: 8]};
      a02 = {4'd0, win_i.win[6][k*8 +: 8]};
      a12 = {4'd0, win_i.win[7][k*8 +: 8]};
      a22 = {4'd0, win_i.win[8][k*8 +: 8]};
      hy = a20 + a22 + (a21 <<< 1) - a00 - a02 - (a01 <<< 1);
      hx = a02 + a22 + (a12 <<< 1) - a00 - a20 - (a10 <<< 1);
      ux[k] = clamp_f(hx);
      uy[k] = clamp_f(hy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[NS-2:0], win_valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ux_q <= ux;
      uy_q <= uy;
      row_q[0] <= win_i.row;
      col_q[0] <= win_i.col;
      done_q[0] <= win_i.done;
      for (int k = 0; k < 3; k++) begin
        n_q[1][k] <= 17'(ux_q[k]) * 17'(ux_q[k]) + 17'(uy_q[k]) * 17'(uy_q[k]);
        rt_q[1][k] <= '0;
      end
      row_q[1] <= row_q[0];
      col_q[1] <= col_q[0];
      done_q[1] <= done_q[0];
      for (int s = 2; s < NS; s++) begin
        for (int k = 0; k < 3; k++) begin
          logic [7:0] t;
          t = rt_q[s-1][k] | (8'd1 << (NS - 1 - s));
          n_q[s][k] <= n_q[s-1][k];
          if (n_q[s-1][k][16]) rt_q[s][k] <= 8'd255;
          else if (17'(t) * 17'(t) <= n_q[s-1][k]) rt_q[s][k] <= t;
          else rt_q[s][k] <= rt_q[s-1][k];
        end
        row_q[s] <= row_q[s-1];
        col_q[s] <= col_q[s-1];
        done_q[s] <= done_q[s-1];
      end
    end
  end

  assign out_valid_o = v_q[NS-1];
  always_comb begin
    res_o.row = row_q[NS-1];
    res_o.col = col_q[NS-1];
    res_o.r = rt_q[NS-1][2];
    res_o.g = rt_q[NS-1][1];
    res_o.b = rt_q[NS-1][0];
    res_o.done = done_q[NS-1];
  end
endmodule

/* src/sobel_edge_magnitude_rgb_core.sv */
// top level of the rgb sobel edge magnitude block
// result path: the window enters the queue as the pixel is accepted, then passes the back pipe
// stages (sums and clamp, squares, root bits) to the output, plus queue wait; each pixel is
// held while the line stores are read into registers, then accepted before the next is read
// a stall at the output holds the back pipe; the 4-entry queue then fills and stalls input
// reset clears counters, window, queue and pipe; width 640, height 480; line stores uncleared
module sobel_edge_magnitude_rgb_core (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_addr_i,
  input  logic [11:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic frame_start_i,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic [11:0] out_row_o,
  output logic [10:0] out_col_o,
  output logic [7:0] red_edge_o,
  output logic [7:0] green_edge_o,
  output logic [7:0] blue_edge_o,
  output logic frame_done_o
);
  sem_pkg::win_t fw, qw;
  sem_pkg::res_t res;
  logic fv, qfull, qv, qpop;

  sem_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .frame_start_i, .red_in_i, .green_in_i, .blue_in_i,
    .win_valid_o(fv), .win_o(fw), .win_stall_i(qfull)
  );

  sem_queue u_queue (
    .clk_i, .rst_ni, .push_i(fv), .data_i(fw), .full_o(qfull),
    .valid_o(qv), .data_o(qw), .pop_i(qpop)
  );

  sem_back u_back (
    .clk_i, .rst_ni, .win_valid_i(qv), .win_i(qw), .win_pop_o(qpop),
    .out_valid_o, .res_o(res), .out_stall_i
  );

  assign out_row_o = res.row;
  assign out_col_o = res.col;
  assign red_edge_o = res.r;
  assign green_edge_o = res.g;
  assign blue_edge_o = res.b;
  assign frame_done_o = res.done;

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qfull |-> !fv) else $error("push into full queue");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qpop |-> qv) else $error("pop from empty queue");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res))
    else $error("result changed under stall");
endmodule

/* verif/tb_sobel_edge_magnitude_rgb_core.sv */
// testbench for the rgb sobel edge magnitude core: directed and random frames checked against a predictor
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude_rgb_core;

  // tracks the raster position and window and holds the edge results still to come
  class edge_scoreboard;
    bit [sem_pkg::PixW-1:0] upper[sem_pkg::MaxWidth];
    bit [sem_pkg::PixW-1:0] middle[sem_pkg::MaxWidth];
    bit [sem_pkg::PixW-1:0] win[6];
    int unsigned col, row;
    int unsigned width_reg = 640, height_reg = 480;
    sem_pkg::res_t pending[$];
    int errors, results, pixels, frames_done;

    function void set_reg(logic [0:0] idx, bit [sem_pkg::CfgW-1:0] v);
      if (idx == sem_pkg::CfgWidth) width_reg = 32'(v);
      else height_reg = 32'(v);
    endfunction

    function bit [7:0] mag(bit [8:0][sem_pkg::PixW-1:0] a, int sh);
      int p[9];
      int hy, hx;
      int unsigned n, root, t;
      for (int i = 0; i < 9; i++) p[i] = (a[i] >> sh) & 255;
      hy = -p[0] - p[2] - 2 * p[1] + 2 * p[7] + p[8] + p[6];
      hx = -p[0] + p[2] - 2 * p[3] + 2 * p[5] + p[8] - p[6];
      hy = hy < 0 ? 0 : (hy > 255 ? 255 : hy);
      hx = hx < 0 ? 0 : (hx > 255 ? 255 : hx);
      n = hx * hx + hy * hy;
      if (n >= 65536) return 8'd255;
      root = 0;
      for (int b = 128; b != 0; b >>= 1) begin
        t = root + b;
        if (t * t <= n) root = t;
      end
      return root[7:0];
    endfunction

    function void note_pixel(bit fs, bit [sem_pkg::PixW-1:0] px);
      int unsigned w, h;
      bit [sem_pkg::PixW-1:0] top, mid;
      bit [8:0][sem_pkg::PixW-1:0] a;
      sem_pkg::res_t e;
      w = width_reg < 3 ? 3 : (width_reg > sem_pkg::MaxWidth ? sem_pkg::MaxWidth : width_reg);
      h = height_reg < 3 ? 3 : height_reg;
      pixels++;
      if (fs) begin
        col = 0;
        row = 0;
      end
      if (col >= w) col = 0;
      if (row >= h) row = 0;
      top = upper[col];
      mid = middle[col];
      if (row >= 2 && col >= 2) begin
        a = {px, win[5], win[2], mid, win[4], win[1], top, win[3], win[0]};
        e.row = 12'(row - 1);
        e.col = 11'(col - 1);
        e.r = mag(a, 16);
        e.g = mag(a, 8);
        e.b = mag(a, 0);
        e.done = (row == h - 1) && (col == w - 1);
        pending.push_back(e);
      end
      win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
      win[3] = top; win[4] = mid; win[5] = px;
      upper[col] = mid;
      middle[col] = px;
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    function void check_result(sem_pkg::res_t got);
      sem_pkg::res_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result row %0d col %0d", $time, got.row, got.col);
        return;
      end
      e = pending.pop_front();
      results++;
      if (e.done) frames_done++;
      if (got != e) begin
        errors++;
        $display("%0t: mismatch exp row %0d col %0d rgb %0d/%0d/%0d done %0d",
                 $time, e.row, e.col, e.r, e.g, e.b, e.done);
        $display("%0t:          act row %0d col %0d rgb %0d/%0d/%0d done %0d",
                 $time, got.row, got.col, got.r, got.g, got.b, got.done);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_addr_i = 1'b0;
  logic [11:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic frame_start_i = 1'b0;
  logic [7:0] red_in_i = '0, green_in_i = '0, blue_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [11:0] out_row_o;
  logic [10:0] out_col_o;
  logic [7:0] red_edge_o, green_edge_o, blue_edge_o;
  logic frame_done_o;

  edge_scoreboard sb = new();
  int idle_pct = 0, stall_pct = 0;
  int hold_ask = 0, hold_seen = 0, hold_left = 0;
  bit restart_due = 1'b0;

  sobel_edge_magnitude_rgb_core u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // output stall, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{row: out_row_o, col: out_col_o, r: red_edge_o, g: green_edge_o,
                        b: blue_edge_o, done: frame_done_o});
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  // register writes leave the frame position stale, so the next item restarts the frame
  task automatic write_reg(logic [0:0] idx, bit [11:0] v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, v);
    restart_due = 1'b1;
  endtask

  task automatic send_pixel(bit fs, bit [sem_pkg::PixW-1:0] px);
    bit f;
    f = fs | restart_due;
    restart_due = 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_start_i <= f;
    {red_in_i, green_in_i, blue_in_i} <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_pixel(f, px);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly step edges with noise so the clamps and the square root see real gradients
  task automatic send_frame(int unsigned w, int unsigned h, bit with_start, int restart_pct);
    bit [sem_pkg::PixW-1:0] lo, hi, px;
    int unsigned k, noise;
    bit vertical, noisy;
    lo = $urandom();
    hi = $urandom();
    k = $urandom_range(w);
    vertical = $urandom_range(1);
    noisy = $urandom_range(99) < 25;
    noise = $urandom_range(3);
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        if (noisy) px = $urandom();
        else begin
          px = ((vertical ? c : r) < k) ? lo : hi;
          px ^= $urandom() & {3{8'((1 << noise) - 1)}};
        end
        send_pixel((with_start && r == 0 && c == 0) || ($urandom_range(999) < restart_pct), px);
      end
    end
  endtask

  initial begin
    int unsigned w, h, phase, pressed, base;
    bit press;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: out-of-range registers clamp to a 3x3 frame
    write_reg(sem_pkg::CfgWidth, 12'd2);
    write_reg(sem_pkg::CfgHeight, 12'd0);
    for (int i = 0; i < 9; i++)   // bright top row over dark: negative vertical sum
      send_pixel(i == 0, i < 3 ? 24'hFFFFFF : 24'h000000);
    for (int i = 0; i < 9; i++)   // frame wraps with no start; bright bottom row
      send_pixel(1'b0, i >= 6 ? 24'hFFFFFF : 24'h000000);
    send_pixel(1'b0, 24'h123456);
    send_pixel(1'b0, 24'hABCDEF);
    for (int i = 0; i < 9; i++)   // restart mid-frame; diagonal edge saturates the root
      send_pixel(i == 0, (i % 3 + i / 3 >= 2) ? 24'hFF80FF : 24'h00007F);
    write_reg(sem_pkg::CfgWidth, 12'd130);
    write_reg(sem_pkg::CfgHeight, 12'd1);
    send_frame(130, 3, 1'b1, 0);
    write_reg(sem_pkg::CfgWidth, 12'd5);
    write_reg(sem_pkg::CfgHeight, 12'd4095);
    send_frame(5, 8, 1'b1, 0);

    pressed = 0;
    base = sb.pixels;
    while (sb.pixels < 1450) begin
      phase = ((sb.pixels - base) / 250) % 4;
      wait_drained();
      idle_pct = phase == 1 ? 50 : (phase == 3 ? 24 : 0);
      stall_pct = phase == 2 ? 50 : (phase == 3 ? 24 : 0);
      w = $urandom_range(9) == 0 ? $urandom_range(20, 40) : $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      press = pressed == 0 && phase == 0;
      if (press) begin
        w = $urandom_range(20, 40);
        h = $urandom_range(4, 8);
      end
      if (!press && $urandom_range(15) == 0) begin
        write_reg(sem_pkg::CfgWidth, 12'($urandom_range(2)));
        write_reg(sem_pkg::CfgHeight, 12'($urandom_range(2)));
        w = 3;
        h = 3;
      end else begin
        write_reg(sem_pkg::CfgWidth, 12'(w));
        write_reg(sem_pkg::CfgHeight, 12'(h));
      end
      if (press) begin
        hold_ask <= hold_ask + 1;
        pressed = 1;
      end
      repeat ($urandom_range(1, 3)) send_frame(w, h, $urandom_range(1), 20);
      if ($urandom_range(3) == 0) drop_valid();
    end
    drop_valid();

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("covered %0d pixels, %0d edge results, %0d complete frames",
             sb.pixels, sb.results, sb.frames_done);
    $display("clamped registers, frame wrap, mid-frame restart, long output hold-off, stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** sobel_edge_magnitude_rgb_core: PASSED **");
    end else begin
      $display("** sobel_edge_magnitude_rgb_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout");
    $display("** sobel_edge_magnitude_rgb_core: FAILED **");
    $finish;
  end
endmodule
